// File: hdl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared widths, operation codes and inter-module structs for the masked
// region memory decoder.
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam int ADDR_W  = 20;
  localparam int DATA_W  = 8;
  localparam int SIZE_W  = 21;
  localparam int SLOT_W  = 3;
  localparam int REGIONS = 8;
  localparam int USED_W  = $clog2(REGIONS + 1);
  localparam int MEM_AW  = 20;

  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_ADD     = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_ENABLE  = 3'd4,
    OP_DISABLE = 3'd5
  } op_t;

  typedef struct packed {
    logic              en;
    logic [2:0]        op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_start;
    logic [SIZE_W-1:0] region_len;
    logic [ADDR_W-1:0] region_mask;
    logic              write_protect;
    logic [SLOT_W-1:0] region_slot;
  } tbl_req_t;

  typedef struct packed {
    logic              hit;
    logic              wprot;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] mask;
  } tbl_res_t;

endpackage

// File: hdl/mrd_region_table.sv
// ----------------------------------------------------------------------------
// mrd_region_table
// Region slots with parallel address compare, lowest-slot priority and the
// add, remove, enable and disable updates. Result registered per request.
// ----------------------------------------------------------------------------
module mrd_region_table (
  input  logic              clk,
  input  logic              rst_n,
  input  mrd_pkg::tbl_req_t req,
  output mrd_pkg::tbl_res_t res_r
);
  import mrd_pkg::*;

  logic [ADDR_W-1:0] start_r [REGIONS];
  logic [SIZE_W-1:0] size_r  [REGIONS];
  logic [ADDR_W-1:0] mask_r  [REGIONS];
  logic [REGIONS-1:0] en_r;
  logic [REGIONS-1:0] wp_r;
  logic [REGIONS-1:0] rm_r;
  logic [USED_W-1:0]  used_r;

  logic [REGIONS-1:0] hit_vec;
  logic [SLOT_W-1:0]  win;
  logic               any_hit;
  logic [SLOT_W-1:0]  free_slot;
  logic               any_free;
  logic               slot_ok;
  tbl_res_t           res_nxt;
  op_t                op;

  assign op = op_t'(req.op);

  always_comb begin
    for (int i = 0; i < REGIONS; i++) begin
      hit_vec[i] = en_r[i] && !rm_r[i] && (req.address >= start_r[i]) &&
                   ({2'b00, req.address} <
                    ({2'b00, start_r[i]} + {1'b0, size_r[i]}));
    end
  end

  always_comb begin
    win       = '0;
    any_hit   = 1'b0;
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = REGIONS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        win     = SLOT_W'(i);
        any_hit = 1'b1;
      end
      if (rm_r[i]) begin
        free_slot = SLOT_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  assign slot_ok = {1'b0, req.region_slot} < used_r;

  always_comb begin
    res_nxt       = '0;
    res_nxt.start = start_r[win];
    res_nxt.mask  = mask_r[win];
    res_nxt.wprot = wp_r[win];
    unique case (op)
      OP_READ, OP_WRITE: res_nxt.hit = any_hit;
      OP_ADD: begin
        if (any_free) begin
          res_nxt.slot = free_slot;
        end else if (used_r < USED_W'(REGIONS)) begin
          res_nxt.slot = used_r[SLOT_W-1:0];
        end else begin
          res_nxt.status = 1'b1;
        end
      end
      OP_REMOVE:             res_nxt.status = !slot_ok;
      OP_ENABLE, OP_DISABLE: res_nxt.status = !slot_ok || rm_r[req.region_slot];
      default:               res_nxt.status = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      wp_r   <= '0;
      rm_r   <= '0;
      used_r <= '0;
    end else if (req.en) begin
      res_r <= res_nxt;
      unique case (op)
        OP_ADD: begin
          if (!res_nxt.status) begin
            start_r[res_nxt.slot] <= req.region_start;
            size_r[res_nxt.slot]  <= req.region_len;
            mask_r[res_nxt.slot]  <= req.region_mask;
            en_r[res_nxt.slot]    <= 1'b1;
            wp_r[res_nxt.slot]    <= req.write_protect;
            rm_r[res_nxt.slot]    <= 1'b0;
            if (!any_free) begin
              used_r <= used_r + USED_W'(1);
            end
          end
        end
        OP_REMOVE: begin
          if (slot_ok) begin
            start_r[req.region_slot] <= '0;
            size_r[req.region_slot]  <= '0;
            mask_r[req.region_slot]  <= '0;
            en_r[req.region_slot]    <= 1'b0;
            wp_r[req.region_slot]    <= 1'b0;
            rm_r[req.region_slot]    <= 1'b1;
          end
        end
        OP_ENABLE, OP_DISABLE: begin
          if (!res_nxt.status) begin
            en_r[req.region_slot] <= (op == OP_ENABLE);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/mrd_byte_store.sv
// ----------------------------------------------------------------------------
// mrd_byte_store
// Single-port synchronous byte RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module mrd_byte_store #(
  parameter int AW = mrd_pkg::MEM_AW
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [mrd_pkg::DATA_W-1:0] wdata,
  output logic [mrd_pkg::DATA_W-1:0] rdata_r
);
  import mrd_pkg::*;

  logic [DATA_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

endmodule

// File: hdl/masked_region_memory_decoder_core.sv
// Path: the input is registered on accept, the region table decodes it (S_DECODE),
// the RAM is accessed (S_ACCESS) and the result is loaded into the output
// register (S_DONE) once that register is free. One item in flight, with the
// result register freeing the input side while a result waits.
// Reset: rst_n synchronous, clears the region table and handshake state; the
// byte store is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// masked_region_memory_decoder_core
// Byte memory behind a table of masked, mirrored address regions.
// ----------------------------------------------------------------------------
module masked_region_memory_decoder_core #(
  parameter int MEM_AW = mrd_pkg::MEM_AW  // byte store holds 2**MEM_AW bytes, 8..20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // address[19:0] data[27:20] region_start[47:28] region_len[68:48]
  // region_mask[88:69] write_protect[89] region_slot[92:90], zero fill
  input  logic [mrd_pkg::IN_TDATA_W-1:0] in_tdata,
  // op[2:0]
  input  logic [mrd_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_data[7:0] hit[8] status[9] slot[12:10], zero fill
  output logic [mrd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mrd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_ACCESS, S_DONE} state_t;

  state_t             state_r;
  tbl_req_t           req_r;
  tbl_req_t           tbl_req;
  tbl_res_t           res;
  logic               out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [DATA_W-1:0]  wdata_r;
  logic [DATA_W-1:0]  rdata;
  logic [ADDR_W-1:0]  map_idx;
  logic               is_rw;
  logic               mem_en;
  logic               mem_we;
  logic [DATA_W-1:0]  rd_byte;
  logic               out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    tbl_req    = req_r;
    tbl_req.en = (state_r == S_DECODE);
  end

  mrd_region_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .res_r (res)
  );

  assign is_rw   = (op_t'(req_r.op) == OP_READ) || (op_t'(req_r.op) == OP_WRITE);
  assign map_idx = res.start + ((req_r.address - res.start) & res.mask);
  assign mem_en  = (state_r == S_ACCESS) && is_rw && res.hit;
  assign mem_we  = (op_t'(req_r.op) == OP_WRITE) && !res.wprot;

  mrd_byte_store #(.AW(MEM_AW)) u_store (
    .clk     (clk),
    .en      (mem_en),
    .we      (mem_we),
    .addr    (map_idx[MEM_AW-1:0]),
    .wdata   (wdata_r),
    .rdata_r (rdata)
  );

  assign rd_byte  = ((op_t'(req_r.op) == OP_READ) && res.hit) ? rdata : '0;
  assign out_load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {3'b000, res.slot, res.status, res.hit, rd_byte};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r.en            <= 1'b0;
            req_r.op            <= in_tuser[2:0];
            req_r.address       <= in_tdata[19:0];
            wdata_r             <= in_tdata[27:20];
            req_r.region_start  <= in_tdata[47:28];
            req_r.region_len    <= in_tdata[68:48];
            req_r.region_mask   <= in_tdata[88:69];
            req_r.write_protect <= in_tdata[89];
            req_r.region_slot   <= in_tdata[92:90];
            state_r             <= S_DECODE;
          end
        end
        S_DECODE: state_r <= S_ACCESS;
        S_ACCESS: state_r <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mrd_checker.sv
// ----------------------------------------------------------------------------
// mrd_checker
// Port-level checks on the decoder core, bound to masked_region_memory_decoder_core.
// ----------------------------------------------------------------------------
module mrd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mrd_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mrd_pkg::*;

  // one item in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8:0] == 9'd0 && out_tdata[12:10] == 3'd0)
    else $error("failed item carries data, hit or slot");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == 8'd0)
    else $error("read data without a hit");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> !out_tdata[9] && out_tdata[12:10] == 3'd0)
    else $error("hit item carries status or slot");

endmodule

bind masked_region_memory_decoder_core mrd_checker u_mrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
